/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QMR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qmr_pkg.sv */
package qmr_pkg;

    // Operation select carried on the input tuser
    localparam logic OP_COMPOSE = 1'b0;
    localparam logic OP_ROTATE  = 1'b1;

    // Per-stage load enables for a product/sum stage pair
    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } qmr_adv_t;

endpackage

/* rtl/qmr_hamilton.sv */
module qmr_hamilton #(
    parameter int PW = 16,
    parameter int QW = 16
) (
    input  logic                        clk,
    input  qmr_pkg::qmr_adv_t           adv,
    input  logic signed [PW-1:0]        p [4],
    input  logic signed [QW-1:0]        q [4],
    output logic signed [PW+QW+1:0]     s [4]
);

    import qmr_pkg::*;

    localparam int MW = PW + QW;
    localparam int SW = PW + QW + 2;

    logic signed [MW-1:0] prod_reg [4][4];
    logic signed [SW-1:0] sum_next [4];
    logic signed [SW-1:0] sum_reg  [4];

    // Form all sixteen cross products
    always_ff @(posedge clk)
    begin
        if (adv.prod_en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    prod_reg[i][j] <= p[i] * q[j];
                end
            end
        end
    end

    // Combine products into the four Hamilton components
    always_comb
    begin
        sum_next[0] = SW'(prod_reg[0][0]) - SW'(prod_reg[1][1])
                    - SW'(prod_reg[2][2]) - SW'(prod_reg[3][3]);
        sum_next[1] = SW'(prod_reg[0][1]) + SW'(prod_reg[1][0])
                    + SW'(prod_reg[2][3]) - SW'(prod_reg[3][2]);
        sum_next[2] = SW'(prod_reg[0][2]) + SW'(prod_reg[2][0])
                    + SW'(prod_reg[3][1]) - SW'(prod_reg[1][3]);
        sum_next[3] = SW'(prod_reg[0][3]) + SW'(prod_reg[3][0])
                    + SW'(prod_reg[1][2]) - SW'(prod_reg[2][1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign s = sum_reg;

endmodule

/* rtl/quaternion_multiply_rotate_unit.sv */
// Throughput: one beat per cycle while the output is not back-pressured; six
// register stages (products, sums, clip, products, sums, clip/output), each
// with its own valid bit and load enable.
// Reset: rst_n clears all stage valid bits asynchronously; data registers
// are not reset.
`include "assert_macros.svh"

module quaternion_multiply_rotate_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // qa_w, qa_x, qa_y, qa_z, qb_w, qb_x, qb_y, qb_z
    input  logic [8*DATA_WIDTH-1:0]                   s_axis_tdata,
    // req_type
    input  logic                                      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // res_w, res_x, res_y, res_z, zero padding
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    // saturated
    output logic                                      m_axis_tuser
);

    import qmr_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int IW    = DATA_WIDTH + 4;
    localparam int CW    = DATA_WIDTH + 1;
    localparam int SW1   = 2 * DATA_WIDTH + 2;
    localparam int SW2   = IW + CW + 2;
    localparam int OUT_W = ((4 * DATA_WIDTH + 7) / 8) * 8;

    // Stage valids and the ready chain
    logic [5:0] vld_reg;
    logic [5:0] vld_next;
    logic [6:0] adv_en;

    // Input unpacking and operand select
    logic signed [DW-1:0]  qa [4];
    logic signed [DW-1:0]  qb [4];
    logic signed [DW-1:0]  op_p [4];
    logic signed [DW-1:0]  op_q [4];
    logic                  in_rot;

    // Side data travelling with the first product
    logic                  type_reg [5];
    logic signed [DW-1:0]  qa0_reg [4];
    logic signed [DW-1:0]  qa1_reg [4];

    // First product sums, clipped intermediate, conjugate
    logic signed [SW1-1:0] s1 [4];
    logic signed [SW1-1:0] sh1 [4];
    logic signed [IW-1:0]  t2_next [4];
    logic signed [IW-1:0]  t2_reg [4];
    logic signed [IW-1:0]  t3_reg [4];
    logic signed [IW-1:0]  t4_reg [4];
    logic signed [CW-1:0]  c2_next [4];
    logic signed [CW-1:0]  c2_reg [4];
    logic signed [CW-1:0]  qa_ext [4];
    logic [3:0]            clip1;
    logic                  flag2_next;
    logic                  flag2_reg;
    logic                  flag3_reg;
    logic                  flag4_reg;

    // Second product and output stage
    logic signed [SW2-1:0] s2 [4];
    logic signed [SW2-1:0] sh2 [4];
    logic signed [DW-1:0]  rot_val [4];
    logic [3:0]            clip2;
    logic signed [DW-1:0]  res_next [4];
    logic signed [DW-1:0]  res_reg [4];
    logic                  sat_next;
    logic                  sat_reg;

    qmr_adv_t h1_adv;
    qmr_adv_t h2_adv;

    // A stage may load when it is empty or its successor loads
    assign adv_en[6] = m_axis_tready;
    assign adv_en[5] = !vld_reg[5] || adv_en[6];
    assign adv_en[4] = !vld_reg[4] || adv_en[5];
    assign adv_en[3] = !vld_reg[3] || adv_en[4];
    assign adv_en[2] = !vld_reg[2] || adv_en[3];
    assign adv_en[1] = !vld_reg[1] || adv_en[2];
    assign adv_en[0] = !vld_reg[0] || adv_en[1];

    assign s_axis_tready = adv_en[0];

    // Advance valid bits; hold any stage whose successor stalls
    always_comb
    begin
        vld_next[0] = adv_en[0] ? s_axis_tvalid : vld_reg[0];
        vld_next[1] = adv_en[1] ? vld_reg[0]    : vld_reg[1];
        vld_next[2] = adv_en[2] ? vld_reg[1]    : vld_reg[2];
        vld_next[3] = adv_en[3] ? vld_reg[2]    : vld_reg[3];
        vld_next[4] = adv_en[4] ? vld_reg[3]    : vld_reg[4];
        vld_next[5] = adv_en[5] ? vld_reg[4]    : vld_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Unpack the beat and pick operands: compose qb*qa, rotate qa*(0,v)
    assign in_rot = (s_axis_tuser == OP_ROTATE);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            qa[k] = s_axis_tdata[k*DW +: DW];
            qb[k] = s_axis_tdata[(k+4)*DW +: DW];
        end
        for (int k = 0; k < 4; k++)
        begin
            op_p[k] = in_rot ? qa[k] : qb[k];
            op_q[k] = in_rot ? qb[k] : qa[k];
        end
        if (in_rot)
        begin
            op_q[0] = '0;
        end
    end

    assign h1_adv.prod_en = adv_en[0];
    assign h1_adv.sum_en  = adv_en[1];

    qmr_hamilton #(
        .PW (DW),
        .QW (DW)
    ) u_first (
        .clk (clk),
        .adv (h1_adv),
        .p   (op_p),
        .q   (op_q),
        .s   (s1)
    );

    // Carry qa alongside the first product
    always_ff @(posedge clk)
    begin
        if (adv_en[0])
        begin
            qa0_reg <= qa;
        end
        if (adv_en[1])
        begin
            qa1_reg <= qa0_reg;
        end
    end

    // Shift and clip the first product; build conj(qa)
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sh1[k] = s1[k] >>> FRAC_BITS;
            if (type_reg[1] == OP_ROTATE)
            begin
                clip1[k] = !((&sh1[k][SW1-1:IW-1]) || !(|sh1[k][SW1-1:IW-1]));
                t2_next[k] = clip1[k]
                    ? {sh1[k][SW1-1], {(IW-1){~sh1[k][SW1-1]}}}
                    : sh1[k][IW-1:0];
            end
            else
            begin
                clip1[k] = !((&sh1[k][SW1-1:DW-1]) || !(|sh1[k][SW1-1:DW-1]));
                t2_next[k] = clip1[k]
                    ? {{5{sh1[k][SW1-1]}}, {(DW-1){~sh1[k][SW1-1]}}}
                    : {{4{sh1[k][DW-1]}}, sh1[k][DW-1:0]};
            end
            qa_ext[k] = {qa1_reg[k][DW-1], qa1_reg[k]};
        end
        c2_next[0] = qa_ext[0];
        c2_next[1] = -qa_ext[1];
        c2_next[2] = -qa_ext[2];
        c2_next[3] = -qa_ext[3];
        flag2_next = |clip1;
    end

    // Advance operation type, intermediate, conjugate and flag down the pipeline
    always_ff @(posedge clk)
    begin
        if (adv_en[0])
        begin
            type_reg[0] <= s_axis_tuser;
        end
        if (adv_en[1])
        begin
            type_reg[1] <= type_reg[0];
        end
        if (adv_en[2])
        begin
            type_reg[2] <= type_reg[1];
            t2_reg      <= t2_next;
            c2_reg      <= c2_next;
            flag2_reg   <= flag2_next;
        end
        if (adv_en[3])
        begin
            type_reg[3] <= type_reg[2];
            t3_reg      <= t2_reg;
            flag3_reg   <= flag2_reg;
        end
        if (adv_en[4])
        begin
            type_reg[4] <= type_reg[3];
            t4_reg      <= t3_reg;
            flag4_reg   <= flag3_reg;
        end
    end

    assign h2_adv.prod_en = adv_en[3];
    assign h2_adv.sum_en  = adv_en[4];

    qmr_hamilton #(
        .PW (IW),
        .QW (CW)
    ) u_second (
        .clk (clk),
        .adv (h2_adv),
        .p   (t2_reg),
        .q   (c2_reg),
        .s   (s2)
    );

    // Shift and clip the rotated vector; pass compose results through
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sh2[k]     = s2[k] >>> FRAC_BITS;
            clip2[k]   = !((&sh2[k][SW2-1:DW-1]) || !(|sh2[k][SW2-1:DW-1]));
            rot_val[k] = clip2[k]
                ? {sh2[k][SW2-1], {(DW-1){~sh2[k][SW2-1]}}}
                : sh2[k][DW-1:0];
        end
        if (type_reg[4] == OP_ROTATE)
        begin
            res_next[0] = '0;
            res_next[1] = rot_val[1];
            res_next[2] = rot_val[2];
            res_next[3] = rot_val[3];
            sat_next    = flag4_reg || (|clip2[3:1]);
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                res_next[k] = t4_reg[k][DW-1:0];
            end
            sat_next = flag4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_en[5])
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign m_axis_tvalid = vld_reg[5];
    assign m_axis_tdata  = OUT_W'({res_reg[3], res_reg[2], res_reg[1], res_reg[0]});
    assign m_axis_tuser  = sat_reg;

    // Checks on the pipeline
    `QMR_ASSERT_SAME(a_empty_pipe_ready, !vld_reg[5], s_axis_tready, "input stalled while output stage empty")
    `QMR_ASSERT_NEXT(a_flag_kept, vld_reg[4] && adv_en[5] && flag4_reg, sat_reg, "intermediate clip flag lost at output")
    `QMR_ASSERT_NEXT(a_rotate_w_zero, vld_reg[4] && adv_en[5] && (type_reg[4] == OP_ROTATE), res_reg[0] == '0, "rotate result real part not zero")

endmodule

/* sim/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qmr_pkg::*;

    localparam int DW        = 16;
    localparam int FRAC      = 14;
    localparam int INTER_W   = DW + 4;
    localparam int CLK_HALF  = 4;
    localparam int RAND_BEATS    = 800;
    localparam int PRESSURE_AT   = 200;
    localparam int PRESSURE_LEN  = 300;
    localparam int DRAIN_CYCLES  = 20;

    // One input beat: operation plus both quaternions
    typedef struct packed {
        logic                 op;
        logic signed [DW-1:0] qa_w;
        logic signed [DW-1:0] qa_x;
        logic signed [DW-1:0] qa_y;
        logic signed [DW-1:0] qa_z;
        logic signed [DW-1:0] qb_w;
        logic signed [DW-1:0] qb_x;
        logic signed [DW-1:0] qb_y;
        logic signed [DW-1:0] qb_z;
    } quat_beat_t;

    // One output beat
    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic                 sat;
    } quat_res_t;

    // Directed row: typed result used only when chk is set
    typedef struct packed {
        logic       chk;
        quat_beat_t stim;
        quat_res_t  want;
    } dir_row_t;

    typedef longint quad_t [4];

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    wire                 s_axis_tready;
    logic [8*DW-1:0]     s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    wire                 m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    wire  [4*DW-1:0]     m_axis_tdata;
    wire                 m_axis_tuser;

    quat_res_t pending_results [$];
    int        mismatches = 0;
    int        rx_count = 0;
    bit        pressure_done = 1'b0;

    dir_row_t directed_rows [15] = '{
        // identity times identity
        '{1'b1, '{OP_COMPOSE, 16384, 0, 0, 0, 16384, 0, 0, 0},
              '{16384, 0, 0, 0, 1'b0}},
        // all zero
        '{1'b1, '{OP_COMPOSE, 0, 0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 1'b0}},
        // most negative everywhere: every component clips
        '{1'b1, '{OP_COMPOSE, -32768, -32768, -32768, -32768,
                  -32768, -32768, -32768, -32768},
              '{-32768, 32767, 32767, 32767, 1'b1}},
        // most positive everywhere
        '{1'b0, '{OP_COMPOSE, 32767, 32767, 32767, 32767,
                  32767, 32767, 32767, 32767}, '0},
        // i times j gives k
        '{1'b1, '{OP_COMPOSE, 0, 0, 16384, 0, 0, 16384, 0, 0},
              '{0, 0, 0, 16384, 1'b0}},
        // scale by minus one
        '{1'b1, '{OP_COMPOSE, -16384, 0, 0, 0, 100, -200, 300, -400},
              '{-100, 200, -300, 400, 1'b0}},
        // shift floors toward minus infinity
        '{1'b1, '{OP_COMPOSE, 1, 0, 0, 0, -1, 0, 0, 0}, '{-1, 0, 0, 0, 1'b0}},
        '{1'b1, '{OP_COMPOSE, 1, 0, 0, 0, 1, 0, 0, 0}, '{0, 0, 0, 0, 1'b0}},
        // alternating bit patterns
        '{1'b0, '{OP_COMPOSE, 21845, -21846, 21845, -21846,
                  -21846, 21845, -21846, 21845}, '0},
        // rotate by identity, real part of qb ignored
        '{1'b1, '{OP_ROTATE, 16384, 0, 0, 0, 12345, 1000, 2000, -3000},
              '{0, 1000, 2000, -3000, 1'b0}},
        // rotate zero vector by a full-scale quaternion
        '{1'b1, '{OP_ROTATE, -32768, -32768, -32768, -32768, -32768, 0, 0, 0},
              '{0, 0, 0, 0, 1'b0}},
        // full-scale rotate, the result clips
        '{1'b0, '{OP_ROTATE, -32768, -32768, -32768, -32768,
                  -32768, -32768, -32768, -32768}, '0},
        '{1'b0, '{OP_ROTATE, 32767, 32767, 32767, 32767,
                  32767, 32767, 32767, 32767}, '0},
        // quarter turn about z
        '{1'b0, '{OP_ROTATE, 11585, 0, 0, 11585, 0, 16384, 0, 0}, '0},
        // mixed extremes, non-unit quaternion
        '{1'b0, '{OP_ROTATE, 0, 32767, -32768, 32767, 1, -32768, 32767, -32768}, '0}
    };

    quaternion_multiply_rotate_unit #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Exact four-term Hamilton sums of p * q, order w, x, y, z
    function automatic void hamilton_sums(input quad_t p, input quad_t q, output quad_t s);
        s[0] = p[0] * q[0] - p[1] * q[1] - p[2] * q[2] - p[3] * q[3];
        s[1] = p[0] * q[1] + p[1] * q[0] + p[2] * q[3] - p[3] * q[2];
        s[2] = p[0] * q[2] + p[2] * q[0] + p[3] * q[1] - p[1] * q[3];
        s[3] = p[0] * q[3] + p[3] * q[0] + p[1] * q[2] - p[2] * q[1];
    endfunction

    // Floor-shift a sum and clip it to a signed width, flagging any clip
    function automatic longint scale_clip(input longint v, input int width, inout logic sat);
        longint hi;
        longint lo;
        longint q;
        hi = (longint'(1) <<< (width - 1)) - 1;
        lo = -hi - 1;
        q  = v >>> FRAC;
        if (q > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (q < lo) begin
            sat = 1'b1;
            return lo;
        end
        return q;
    endfunction

    function automatic quat_res_t predict_product(input quat_beat_t b);
        quad_t     qa;
        quad_t     qb;
        quad_t     vec;
        quad_t     conj;
        quad_t     mid;
        quad_t     sums;
        quad_t     r;
        logic      sat;
        quat_res_t res;
        sat = 1'b0;
        qa  = '{longint'(b.qa_w), longint'(b.qa_x), longint'(b.qa_y), longint'(b.qa_z)};
        qb  = '{longint'(b.qb_w), longint'(b.qb_x), longint'(b.qb_y), longint'(b.qb_z)};
        if (b.op == OP_ROTATE) begin
            vec  = '{0, qb[1], qb[2], qb[3]};
            conj = '{qa[0], -qa[1], -qa[2], -qa[3]};
            hamilton_sums(qa, vec, sums);
            for (int i = 0; i < 4; i++)
                mid[i] = scale_clip(sums[i], INTER_W, sat);
            hamilton_sums(mid, conj, sums);
            r[0] = 0;
            for (int i = 1; i < 4; i++)
                r[i] = scale_clip(sums[i], DW, sat);
        end
        else begin
            hamilton_sums(qb, qa, sums);
            for (int i = 0; i < 4; i++)
                r[i] = scale_clip(sums[i], DW, sat);
        end
        res.w   = DW'(r[0]);
        res.x   = DW'(r[1]);
        res.y   = DW'(r[2]);
        res.z   = DW'(r[3]);
        res.sat = sat;
        return res;
    endfunction

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Component value by flavor: full range, near unit scale, or an edge value
    function automatic logic signed [DW-1:0] rand_component(input int flavor);
        logic signed [DW-1:0] edges [8];
        edges = '{-32768, -32767, -16384, -1, 0, 1, 16384, 32767};
        case (flavor)
            0:       return DW'($urandom);
            1:       return DW'(int'($urandom_range(0, 32768)) - 16384);
            default: return edges[$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic quat_beat_t rand_beat();
        quat_beat_t b;
        int         r;
        int         flavor;
        r = $urandom_range(0, 99);
        flavor = (r < 50) ? 0 : (r < 85) ? 1 : 2;
        b.op   = $urandom_range(0, 1) ? OP_ROTATE : OP_COMPOSE;
        b.qa_w = rand_component(flavor);
        b.qa_x = rand_component(flavor);
        b.qa_y = rand_component(flavor);
        b.qa_z = rand_component(flavor);
        b.qb_w = rand_component(flavor);
        b.qb_x = rand_component(flavor);
        b.qb_y = rand_component(flavor);
        b.qb_z = rand_component(flavor);
        return b;
    endfunction

    // Offer one beat after an optional gap and hold it until accepted
    task automatic send_beat(input quat_beat_t b, input int gap);
        if (gap > 0) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= b.op;
        s_axis_tdata  <= {b.qb_z, b.qb_y, b.qb_x, b.qb_w, b.qa_z, b.qa_y, b.qa_x, b.qa_w};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Compare each output beat with the oldest expectation
    always @(posedge clk) begin : check_output
        quat_res_t got;
        quat_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.w   = m_axis_tdata[DW-1:0];
            got.x   = m_axis_tdata[2*DW-1:DW];
            got.y   = m_axis_tdata[3*DW-1:2*DW];
            got.z   = m_axis_tdata[4*DW-1:3*DW];
            got.sat = m_axis_tuser;
            rx_count++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output beat, expected none, got w=%0d x=%0d y=%0d z=%0d sat=%0d",
                         $time, got.w, got.x, got.y, got.z, got.sat);
            end
            else begin
                want = pending_results.pop_front();
                check_field("res_w", want.w, got.w);
                check_field("res_x", want.x, got.x);
                check_field("res_y", want.y, got.y);
                check_field("res_z", want.z, got.z);
                check_field("saturated", want.sat, got.sat);
            end
        end
    end

    // Output ready: random runs, plus one long hold-off to back up the pipe
    initial begin : drive_ready
        int   run;
        logic level;
        run   = 0;
        level = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!pressure_done && rx_count >= PRESSURE_AT) begin
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_LEN) @(negedge clk);
                pressure_done = 1'b1;
                run = 0;
            end
            else begin
                if (run == 0) begin
                    level = !level;
                    run   = level ? $urandom_range(1, 40) : pick_gap() + 1;
                end
                m_axis_tready <= level;
                run--;
            end
        end
    end

    // Stimulus: directed table, then random beats, then drain
    initial begin : stimulus
        quat_beat_t b;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].stim, pick_gap());
            if (directed_rows[i].chk)
                pending_results.push_back(directed_rows[i].want);
            else
                pending_results.push_back(predict_product(directed_rows[i].stim));
        end

        for (int n = 0; n < RAND_BEATS; n++) begin
            b = rand_beat();
            send_beat(b, pick_gap());
            pending_results.push_back(predict_product(b));
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hang guard
    initial begin : watchdog
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/qmr_pkg.sv
rtl/qmr_hamilton.sv
rtl/quaternion_multiply_rotate_unit.sv
sim/testbench.sv
